FILE: src/cwh_pkg.sv
// Shared types, codes and constants of the coincidence walk histogram.
package cwh_pkg;

	localparam int BIN_W   = 13;
	localparam int STAMP_W = 31;
	localparam int CNT_W   = 32;
	localparam int RDX_W   = 10;
	localparam int WIN_W   = 16;
	localparam int GATE_W  = 14;
	localparam int COL_W   = 15;
	localparam int LANES   = 4;

	localparam int DEF_ENERGY_ROWS = 1024;
	localparam int DEF_TIME_COLS   = 1024;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [BIN_W-1:0]  GATE_LOW_RST  = 13'd0;
	localparam logic [GATE_W-1:0] GATE_HIGH_RST = 14'd8192;
	localparam logic [WIN_W-1:0]  WINDOW_RST    = 16'd100;
	localparam logic [BIN_W-1:0]  OFFSET_RST    = 13'd2000;

	typedef enum logic [1:0] {
		CMD_EVENT = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_GATE_LOW  = 2'd0,
		REG_GATE_HIGH = 2'd1,
		REG_WINDOW    = 2'd2,
		REG_OFFSET    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [BIN_W-1:0]  gate_low;
		logic [GATE_W-1:0] gate_high;
		logic [WIN_W-1:0]  match_window;
		logic [BIN_W-1:0]  delay_offset;
	} cfg_t;

	typedef struct packed {
		logic [LANES-1:0] mask;
		logic             coinc;
		logic             gated;
		logic             fill;
		logic             oor;
		logic             rd_ok;
	} flags_t;

endpackage

FILE: src/cwh_lane.sv
// One stamp lane: checks its stamp against the smallest stamp and the window.
module cwh_lane
	import cwh_pkg::*;
(
	input  logic [STAMP_W-1:0] stamp,
	input  logic [STAMP_W-1:0] min_stamp,
	input  logic [WIN_W-1:0]   window,
	output logic               near
);

	logic [STAMP_W-1:0] spread;

	// min_stamp never exceeds stamp, so the difference does not wrap
	assign spread = stamp - min_stamp;
	assign near   = spread <= {{(STAMP_W-WIN_W){1'b0}}, window};

endmodule

FILE: src/cwh_merge.sv
// Merge of the lane results: coincidence, gate, bin address and range checks.
module cwh_merge
	import cwh_pkg::*;
#(
	parameter int ENERGY_ROWS = DEF_ENERGY_ROWS,
	parameter int TIME_COLS   = DEF_TIME_COLS,
	localparam int RW = $clog2(ENERGY_ROWS),
	localparam int CW = $clog2(TIME_COLS)
) (
	input  logic [LANES-1:0] near,
	input  cmd_t             cmd,
	input  cfg_t             cfg,
	input  logic [BIN_W-1:0] ref_energy,
	input  logic [BIN_W-1:0] ref_time,
	input  logic [BIN_W-1:0] det_energy,
	input  logic [BIN_W-1:0] det_time,
	input  logic [RDX_W-1:0] read_row,
	input  logic [RDX_W-1:0] read_col,
	output flags_t           flags,
	output logic [RW+CW-1:0] addr
);

	localparam logic [GATE_W-1:0]       ROWS_LIM = GATE_W'(ENERGY_ROWS);
	localparam logic [GATE_W-1:0]       COLS_LIM = GATE_W'(TIME_COLS);
	localparam logic signed [COL_W-1:0] COLS_S   = COL_W'(TIME_COLS);

	logic                    is_event;
	logic [GATE_W-1:0]       lo, hi, gl, refe;
	logic                    in_gate;
	logic signed [COL_W-1:0] col;
	logic                    row_ok, col_ok;
	logic [GATE_W-1:0]       dete, rrow, rcol;
	logic                    rd_ok;

	assign is_event = (cmd == CMD_EVENT);
	assign gl       = {1'b0, cfg.gate_low};
	assign refe     = {1'b0, ref_energy};
	assign dete     = {1'b0, det_energy};
	assign rrow     = {{(GATE_W-RDX_W){1'b0}}, read_row};
	assign rcol     = {{(GATE_W-RDX_W){1'b0}}, read_col};

	// use the bounds swapped when the low one is larger
	assign lo      = (gl > cfg.gate_high) ? cfg.gate_high : gl;
	assign hi      = (gl > cfg.gate_high) ? gl : cfg.gate_high;
	assign in_gate = (refe >= lo) && (refe <= hi);

	assign col = $signed({2'b00, det_time}) - $signed({2'b00, ref_time})
		+ $signed({2'b00, cfg.delay_offset});

	// column zero is never filled
	assign col_ok = (col > 0) && (col < COLS_S);
	assign row_ok = dete < ROWS_LIM;
	assign rd_ok  = (cmd == CMD_READ) && (rrow < ROWS_LIM) && (rcol < COLS_LIM);

	always_comb begin
		flags.mask  = is_event ? near : '0;
		flags.coinc = is_event && (&near);
		flags.gated = flags.coinc && in_gate;
		flags.fill  = flags.gated && row_ok && col_ok;
		flags.oor   = flags.gated && !(row_ok && col_ok);
		flags.rd_ok = rd_ok;
		if (is_event) begin
			addr = {dete[RW-1:0], col[CW-1:0]};
		end else begin
			addr = {rrow[RW-1:0], rcol[CW-1:0]};
		end
	end

endmodule

FILE: src/cwh_store.sv
// Histogram count memory: one write port, one read port with registered data.
module cwh_store
	import cwh_pkg::*;
#(
	parameter int AW = 20
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [CNT_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [CNT_W-1:0] rdata
);

	logic [CNT_W-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/coincidence_walk_histogram.sv
// Top level of the coincidence-gated two-dimensional walk histogram.
//
// Each input beat carries a command and the heads of four channels (reference
// energy, reference time, detector energy, detector time), each a bin and a
// 31-bit stamp. An event beat runs through four stamp lanes that compare every
// stamp to the smallest one against match_window; the merge stage forms the
// advance mask, the coincidence and gate flags, and the histogram address
// {det_energy, det_time - ref_time + delay_offset}. A gated in-range event does
// a read-modify-write of its 32-bit saturating bin; every gated event bumps the
// saturating event total. A read beat returns one bin (0 outside the store), a
// clear beat zeroes the total and the whole store. Every beat gives one result
// beat. Event, read and no-op beats are taken one at a time through capture,
// minimum, lanes/merge, memory read and update, the registered read and then
// the write of the count memory; the update waits while the result register
// is full and stalled. A clear beat adds a sweep over all 2**(clog2(ENERGY_ROWS) +
// clog2(TIME_COLS)) words (1,048,576 at the defaults) that writes zero to one
// memory word per cycle; the same sweep runs after reset. in_stall stays high
// during the sweep and while a beat is in work; APB writes are taken at any
// time but are meant to happen only while the block is idle. A finished result
// waits in the output register while the next beat is already accepted.
module coincidence_walk_histogram
	import cwh_pkg::*;
#(
	parameter int ENERGY_ROWS = DEF_ENERGY_ROWS,
	parameter int TIME_COLS   = DEF_TIME_COLS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            command,
	input  logic [BIN_W-1:0]      ref_energy,
	input  logic [STAMP_W-1:0]    ref_energy_stamp,
	input  logic [BIN_W-1:0]      ref_time,
	input  logic [STAMP_W-1:0]    ref_time_stamp,
	input  logic [BIN_W-1:0]      det_energy,
	input  logic [STAMP_W-1:0]    det_energy_stamp,
	input  logic [BIN_W-1:0]      det_time,
	input  logic [STAMP_W-1:0]    det_time_stamp,
	input  logic [RDX_W-1:0]      read_row,
	input  logic [RDX_W-1:0]      read_col,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LANES-1:0]      advance_mask,
	output logic                  coincident,
	output logic                  gated,
	output logic                  bin_filled,
	output logic                  out_of_range,
	output logic [CNT_W-1:0]      bin_value,
	output logic [CNT_W-1:0]      event_total
);

	localparam int RW = $clog2(ENERGY_ROWS);
	localparam int CW = $clog2(TIME_COLS);
	localparam int AW = RW + CW;

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_MIN    = 6'b000100,
		ST_LANE   = 6'b001000,
		ST_READ   = 6'b010000,
		ST_UPDATE = 6'b100000
	} state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

	state_t             state_q, state_d;
	cfg_t               cfg_q;
	reg_idx_t           reg_idx;
	logic               cfg_we;

	// captured beat
	cmd_t               cmd_q;
	logic [BIN_W-1:0]   refe_q, reft_q, dete_q, dett_q;
	logic [STAMP_W-1:0] stamp_q [LANES];
	logic [RDX_W-1:0]   rrow_q, rcol_q;

	logic [STAMP_W-1:0] m01, m23, min_stamp;
	logic [STAMP_W-1:0] min_q;
	logic [LANES-1:0]   near;
	flags_t             flags, flags_q;
	logic [AW-1:0]      addr, addr_q;
	logic [AW-1:0]      clr_cnt_q;

	logic               in_acc, out_free, do_update;
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr;
	logic [CNT_W-1:0]   mem_wdata, mem_rdata;
	logic [CNT_W-1:0]   total_q, total_next;
	logic               out_valid_q;

	// configuration registers, decoded by word address
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_we  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_low     <= GATE_LOW_RST;
			cfg_q.gate_high    <= GATE_HIGH_RST;
			cfg_q.match_window <= WINDOW_RST;
			cfg_q.delay_offset <= OFFSET_RST;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_GATE_LOW:  cfg_q.gate_low     <= pwdata[BIN_W-1:0];
				REG_GATE_HIGH: cfg_q.gate_high    <= pwdata[GATE_W-1:0];
				REG_WINDOW:    cfg_q.match_window <= pwdata[WIN_W-1:0];
				REG_OFFSET:    cfg_q.delay_offset <= pwdata[BIN_W-1:0];
				default:       cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GATE_LOW:  prdata = APB_DATA_W'(cfg_q.gate_low);
			REG_GATE_HIGH: prdata = APB_DATA_W'(cfg_q.gate_high);
			REG_WINDOW:    prdata = APB_DATA_W'(cfg_q.match_window);
			REG_OFFSET:    prdata = APB_DATA_W'(cfg_q.delay_offset);
			default:       prdata = '0;
		endcase
	end

	// handshakes: take a beat only when idle; load the result register when
	// it is empty or being drained in this cycle
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign do_update = (state_q == ST_UPDATE) && out_free;

	// capture the beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q      <= cmd_t'(command);
			refe_q     <= ref_energy;
			reft_q     <= ref_time;
			dete_q     <= det_energy;
			dett_q     <= det_time;
			stamp_q[0] <= ref_energy_stamp;
			stamp_q[1] <= ref_time_stamp;
			stamp_q[2] <= det_energy_stamp;
			stamp_q[3] <= det_time_stamp;
			rrow_q     <= read_row;
			rcol_q     <= read_col;
		end
	end

	// smallest stamp, two compare levels
	assign m01       = (stamp_q[1] < stamp_q[0]) ? stamp_q[1] : stamp_q[0];
	assign m23       = (stamp_q[3] < stamp_q[2]) ? stamp_q[3] : stamp_q[2];
	assign min_stamp = (m23 < m01) ? m23 : m01;

	always_ff @(posedge clk) begin
		if (state_q == ST_MIN) begin
			min_q <= min_stamp;
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		cwh_lane u_lane (
			.stamp     (stamp_q[g]),
			.min_stamp (min_q),
			.window    (cfg_q.match_window),
			.near      (near[g])
		);
	end

	cwh_merge #(
		.ENERGY_ROWS (ENERGY_ROWS),
		.TIME_COLS   (TIME_COLS)
	) u_merge (
		.near       (near),
		.cmd        (cmd_q),
		.cfg        (cfg_q),
		.ref_energy (refe_q),
		.ref_time   (reft_q),
		.det_energy (dete_q),
		.det_time   (dett_q),
		.read_row   (rrow_q),
		.read_col   (rcol_q),
		.flags      (flags),
		.addr       (addr)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_LANE) begin
			flags_q <= flags;
			addr_q  <= addr;
		end
	end

	// count memory: the sweep writes zeros, an update writes the bumped count
	assign mem_re    = (state_q == ST_READ);
	assign mem_we    = (state_q == ST_CLEAR) || (do_update && flags_q.fill);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : addr_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : sat_inc(mem_rdata);

	cwh_store #(
		.AW (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	always_comb begin
		if (cmd_q == CMD_CLEAR) begin
			total_next = '0;
		end else if (flags_q.gated) begin
			total_next = sat_inc(total_q);
		end else begin
			total_next = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (do_update) begin
			total_q <= total_next;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_cnt_q == '1) state_d = ST_IDLE;
			ST_IDLE:   if (in_acc) state_d = ST_MIN;
			ST_MIN:    state_d = ST_LANE;
			ST_LANE:   state_d = ST_READ;
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (out_free) begin
					state_d = (cmd_q == CMD_CLEAR) ? ST_CLEAR : ST_IDLE;
				end
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end else begin
				clr_cnt_q <= '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_update) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_update) begin
			advance_mask <= flags_q.mask;
			coincident   <= flags_q.coinc;
			gated        <= flags_q.gated;
			bin_filled   <= flags_q.fill;
			out_of_range <= flags_q.oor;
			bin_value    <= flags_q.rd_ok ? mem_rdata : '0;
			event_total  <= total_next;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: test/coincidence_walk_histogram_tb.sv
// Testbench for the coincidence walk histogram: random and directed beats checked against a model.
`timescale 1ns / 100ps

module coincidence_walk_histogram_tb;
	import cwh_pkg::*;

	localparam int ROWS         = DEF_ENERGY_ROWS;
	localparam int COLS         = DEF_TIME_COLS;
	localparam int PHASE_BEATS  = 230;
	localparam int CALM_BEATS   = 40;
	localparam int SETTLE       = 20;
	// Two full memory sweeps (reset and one clear) dominate the run time.
	localparam int LIMIT_CYCLES = 10_000_000;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	// One input beat; lane order follows the advance mask bits:
	// 0 ref energy, 1 ref time, 2 det energy, 3 det time.
	typedef struct packed {
		cmd_t                            cmd;
		logic [LANES-1:0][BIN_W-1:0]     bin;
		logic [LANES-1:0][STAMP_W-1:0]   stamp;
		logic [RDX_W-1:0]                row;
		logic [RDX_W-1:0]                col;
	} beat_t;

	typedef struct packed {
		logic [LANES-1:0] mask;
		logic             coinc;
		logic             gated;
		logic             filled;
		logic             oor;
		logic [CNT_W-1:0] value;
		logic [CNT_W-1:0] total;
	} walk_result_t;

	// Holds a copy of the registers, the bin counts and the gated total, and
	// keeps the expected results in order of acceptance.
	class walk_hist_checker;
		cfg_t                 cfg;
		int unsigned          counts[int unsigned];
		logic [CNT_W-1:0]     gated_total;
		walk_result_t         awaited[$];
		int                   errors;
		int                   seen;

		function new();
			cfg = {GATE_LOW_RST, GATE_HIGH_RST, WINDOW_RST, OFFSET_RST};
			gated_total = '0;
			errors = 0;
			seen = 0;
		endfunction

		task report(string msg);
			$display("%t mismatch: %s", $time, msg);
			errors++;
		endtask

		function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function void write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] v);
			case (idx)
				REG_GATE_LOW:  cfg.gate_low     = v[BIN_W-1:0];
				REG_GATE_HIGH: cfg.gate_high    = v[GATE_W-1:0];
				REG_WINDOW:    cfg.match_window = v[WIN_W-1:0];
				REG_OFFSET:    cfg.delay_offset = v[BIN_W-1:0];
			endcase
		endfunction

		function logic [APB_DATA_W-1:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_GATE_LOW:  return APB_DATA_W'(cfg.gate_low);
				REG_GATE_HIGH: return APB_DATA_W'(cfg.gate_high);
				REG_WINDOW:    return APB_DATA_W'(cfg.match_window);
				default:       return APB_DATA_W'(cfg.delay_offset);
			endcase
		endfunction

		// Predict the result of an accepted beat and queue it.
		function void note_beat(beat_t b);
			walk_result_t       r;
			logic [STAMP_W-1:0] low_stamp;
			logic [GATE_W-1:0]  lo, hi, swap;
			int                 col;
			int unsigned        key;
			r = '0;
			case (b.cmd)
				CMD_EVENT: begin
					low_stamp = b.stamp[0];
					for (int i = 1; i < LANES; i++)
						if (b.stamp[i] < low_stamp)
							low_stamp = b.stamp[i];
					for (int i = 0; i < LANES; i++)
						if (32'(b.stamp[i] - low_stamp) <= 32'(cfg.match_window))
							r.mask[i] = 1'b1;
					if (r.mask == '1) begin
						r.coinc = 1'b1;
						lo = GATE_W'(cfg.gate_low);
						hi = cfg.gate_high;
						if (lo > hi) begin
							swap = lo;
							lo = hi;
							hi = swap;
						end
						if (GATE_W'(b.bin[0]) >= lo && GATE_W'(b.bin[0]) <= hi) begin
							r.gated = 1'b1;
							gated_total = sat_inc(gated_total);
							col = int'(b.bin[3]) - int'(b.bin[1]) + int'(cfg.delay_offset);
							if (col > 0 && col < COLS && int'(b.bin[2]) < ROWS) begin
								key = int'(b.bin[2]) * COLS + col;
								counts[key] = counts.exists(key) ? sat_inc(counts[key]) : 1;
								r.filled = 1'b1;
							end else begin
								r.oor = 1'b1;
							end
						end
					end
				end
				CMD_READ: begin
					key = int'(b.row) * COLS + int'(b.col);
					if (b.row < ROWS && b.col < COLS && counts.exists(key))
						r.value = counts[key];
				end
				CMD_CLEAR: begin
					counts.delete();
					gated_total = '0;
				end
				default: ;
			endcase
			r.total = gated_total;
			awaited.push_back(r);
		endfunction

		task compare(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0h expected %0h", seen, name, got,
					want));
		endtask

		task check_result(walk_result_t got);
			walk_result_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result %0d arrived with no beat pending", seen));
			end else begin
				want = awaited.pop_front();
				compare("advance_mask", CNT_W'(got.mask), CNT_W'(want.mask));
				compare("coincident", CNT_W'(got.coinc), CNT_W'(want.coinc));
				compare("gated", CNT_W'(got.gated), CNT_W'(want.gated));
				compare("bin_filled", CNT_W'(got.filled), CNT_W'(want.filled));
				compare("out_of_range", CNT_W'(got.oor), CNT_W'(want.oor));
				compare("bin_value", got.value, want.value);
				compare("event_total", got.total, want.total);
			end
			seen++;
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid, in_stall;
	logic [1:0]            command;
	logic [BIN_W-1:0]      ref_energy, ref_time, det_energy, det_time;
	logic [STAMP_W-1:0]    ref_energy_stamp, ref_time_stamp, det_energy_stamp, det_time_stamp;
	logic [RDX_W-1:0]      read_row, read_col;
	logic                  out_valid, out_stall;
	logic [LANES-1:0]      advance_mask;
	logic                  coincident, gated, bin_filled, out_of_range;
	logic [CNT_W-1:0]      bin_value, event_total;

	walk_hist_checker hist_sb = new();
	bit          quiet = 1'b0;	// suppress idling on both sides
	int          stall_left = 0;
	int unsigned cycles = 0;

	coincidence_walk_histogram dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .command,
		.ref_energy, .ref_energy_stamp, .ref_time, .ref_time_stamp,
		.det_energy, .det_energy_stamp, .det_time, .det_time_stamp,
		.read_row, .read_col,
		.out_valid, .out_stall,
		.advance_mask, .coincident, .gated, .bin_filled, .out_of_range,
		.bin_value, .event_total
	);

	always #10 clk = ~clk;

	// Idle length: mostly none, some short, a few long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(99, 0);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(9, 4);
		return $urandom_range(40, 10);
	endfunction

	// Receiver side: hold off result beats in random bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = idle_len();
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Check every result beat taken at this edge.
	always @(posedge clk) begin : watch_results
		walk_result_t got;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			got = {advance_mask, coincident, gated, bin_filled, out_of_range, bin_value,
				event_total};
			hist_sb.check_result(got);
		end
	end

	// Watchdog: give up if the run hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("coincidence_walk_histogram_tb failed");
			$finish;
		end
	end

	// Drive one beat and hold it until taken; then maybe drop valid for a gap.
	task automatic send_beat(beat_t b);
		int gap;
		gap = idle_len();
		command          <= b.cmd;
		ref_energy       <= b.bin[0];
		ref_time         <= b.bin[1];
		det_energy       <= b.bin[2];
		det_time         <= b.bin[3];
		ref_energy_stamp <= b.stamp[0];
		ref_time_stamp   <= b.stamp[1];
		det_energy_stamp <= b.stamp[2];
		det_time_stamp   <= b.stamp[3];
		read_row         <= b.row;
		read_col         <= b.col;
		in_valid         <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		hist_sb.note_beat(b);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (hist_sb.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write a register (setup, access), then read it back the same way.
	task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		hist_sb.write_reg(idx, val);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== hist_sb.reg_value(idx))
			hist_sb.report($sformatf("register %s read %0h expected %0h", idx.name(),
				prdata, hist_sb.reg_value(idx)));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic beat_t event_beat(logic [STAMP_W-1:0] s0, s1, s2, s3,
			logic [BIN_W-1:0] re, rt, de, dt);
		beat_t b;
		b = '0;
		b.cmd = CMD_EVENT;
		b.stamp[0] = s0;
		b.stamp[1] = s1;
		b.stamp[2] = s2;
		b.stamp[3] = s3;
		b.bin[0] = re;
		b.bin[1] = rt;
		b.bin[2] = de;
		b.bin[3] = dt;
		return b;
	endfunction

	function automatic beat_t plain_beat(cmd_t c, logic [RDX_W-1:0] row, col);
		beat_t b;
		b = '0;
		b.cmd = c;
		b.row = row;
		b.col = col;
		return b;
	endfunction

	// Random beat shaped by the current settings: mostly events that coincide,
	// pass the gate and land on a small set of hot bins, so reads see counts.
	function automatic beat_t random_beat();
		beat_t              b;
		int                 pick, shape, lo, hi, row, col, d, t_lo, t_hi, rt, k, j;
		logic [31:0]        win, base;
		pick = $urandom_range(99, 0);
		for (int i = 0; i < LANES; i++) begin
			b.bin[i]   = BIN_W'($urandom);
			b.stamp[i] = STAMP_W'($urandom);
		end
		b.row = RDX_W'($urandom);
		b.col = RDX_W'($urandom);
		if (pick < 4) begin
			b.cmd = CMD_NOP;
		end else if (pick < 24) begin
			b.cmd = CMD_READ;
			shape = $urandom_range(99, 0);
			if (shape < 60) begin
				b.row = RDX_W'($urandom_range(7, 0));
				b.col = RDX_W'($urandom_range(15, 0));
			end else if (shape < 72) begin
				b.row = $urandom_range(1, 0) ? '1 : '0;
				b.col = $urandom_range(1, 0) ? '1 : '0;
			end
		end else begin
			b.cmd = CMD_EVENT;
			win = 32'(hist_sb.cfg.match_window);
			shape = $urandom_range(99, 0);
			if (shape < 65) begin
				base = $urandom_range(32'(STAMP_MAX) - win, 0);
				for (int i = 0; i < LANES; i++)
					b.stamp[i] = STAMP_W'(base + $urandom_range(win, 0));
			end else if (shape < 80) begin
				// Put one lane exactly on the window edge or one past it.
				base = $urandom_range(32'(STAMP_MAX) - win - 1, 0);
				for (int i = 0; i < LANES; i++)
					b.stamp[i] = STAMP_W'(base + $urandom_range(win, 0));
				k = $urandom_range(3, 0);
				j = (k + 1 + $urandom_range(2, 0)) % LANES;
				b.stamp[k] = STAMP_W'(base);
				b.stamp[j] = STAMP_W'(base + win + $urandom_range(1, 0));
			end else if (shape < 90) begin
				for (int i = 0; i < LANES; i++)
					b.stamp[i] = STAMP_W'(32'(STAMP_MAX) - $urandom_range(win, 0));
			end
			lo = int'(hist_sb.cfg.gate_low);
			hi = int'(hist_sb.cfg.gate_high);
			if (lo > hi) begin
				d = lo;
				lo = hi;
				hi = d;
			end
			if (hi > 8191)
				hi = 8191;
			if ($urandom_range(99, 0) < 75)
				b.bin[0] = BIN_W'($urandom_range(hi, lo));
			if ($urandom_range(99, 0) < 75) begin
				shape = $urandom_range(99, 0);
				if (shape < 80)
					row = $urandom_range(7, 0);
				else if (shape < 90)
					row = $urandom_range(ROWS - 1, 0);
				else if (shape < 95)
					row = ROWS - 1;
				else
					row = $urandom_range(8191, ROWS);
				shape = $urandom_range(99, 0);
				if (shape < 80)
					col = $urandom_range(15, 1);
				else if (shape < 88)
					col = $urandom_range(COLS - 1, 1);
				else if (shape < 92)
					col = COLS - 1;
				else if (shape < 95)
					col = 0;
				else if (shape < 97)
					col = COLS;
				else
					col = -int'($urandom_range(50, 1));
				// Solve det_time - ref_time = col - offset within 13 bits.
				d = col - int'(hist_sb.cfg.delay_offset);
				if (d < -8191)
					d = -8191;
				t_lo = (d < 0) ? -d : 0;
				t_hi = (d > 0) ? 8191 - d : 8191;
				rt = $urandom_range(t_hi, t_lo);
				b.bin[1] = BIN_W'(rt);
				b.bin[2] = BIN_W'(row);
				b.bin[3] = BIN_W'(rt + d);
			end
		end
		return b;
	endfunction

	initial begin
		cfg_t  plan[5];
		beat_t script[$];
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		in_valid         <= 1'b0;
		command          <= CMD_NOP;
		ref_energy       <= '0;
		ref_time         <= '0;
		det_energy       <= '0;
		det_time         <= '0;
		ref_energy_stamp <= '0;
		ref_time_stamp   <= '0;
		det_energy_stamp <= '0;
		det_time_stamp   <= '0;
		read_row         <= '0;
		read_col         <= '0;
		out_stall        <= 1'b0;

		// gate_low, gate_high, match_window, delay_offset; swapped gates,
		// zero and full windows, zero and full offsets.
		plan[0] = {13'd500, 14'd6000, 16'd0, 13'd0};
		plan[1] = {13'd8191, 14'd0, 16'd65535, 13'd8191};
		plan[2] = {13'd4000, 14'd1000, 16'd1000, 13'd512};
		plan[3] = {13'd7000, 14'd8192, 16'd37, 13'd1};
		plan[4] = {13'd0, 14'd0, 16'd5000, 13'd1023};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats under the reset settings (gate 0..8192, window 100,
		// offset 2000). The first waits out the clearing sweep after reset.
		script.push_back(plain_beat(CMD_READ, 0, 0));
		script.push_back(event_beat(1000, 1000, 1000, 1000, 0, 2000, 3, 5));
		// stamp spread exactly equal to the window still coincides
		script.push_back(event_beat(1000, 1100, 1050, 1000, 8191, 2000, 3, 5));
		script.push_back(plain_beat(CMD_READ, 3, 5));
		// one past the window: only the lanes near the minimum advance
		script.push_back(event_beat(1000, 1101, 1000, 1000, 7, 2000, 3, 5));
		// column zero and a negative column are out of range
		script.push_back(event_beat(50, 50, 50, 50, 100, 2000, 4, 0));
		script.push_back(event_beat(50, 50, 50, 50, 100, 8191, 4, 0));
		// last column fills, one past it does not
		script.push_back(event_beat(70, 60, 80, 90, 4096, 1000, 1023, 23));
		script.push_back(event_beat(70, 60, 80, 90, 4096, 1000, 1023, 24));
		// row too large
		script.push_back(event_beat(9, 9, 9, 9, 1, 2000, 1024, 5));
		script.push_back(event_beat(9, 9, 9, 9, 1, 8191, 8191, 8191));
		// extreme stamps: with one zero stamp only that lane advances; all-maximum stamps coincide
		script.push_back(event_beat(STAMP_MAX, 0, STAMP_MAX, STAMP_MAX, 0, 0, 0, 0));
		script.push_back(event_beat(STAMP_MAX, STAMP_MAX, STAMP_MAX, STAMP_MAX, 8191,
			1000, 1023, 23));
		script.push_back(plain_beat(CMD_READ, 1023, 1023));
		script.push_back(plain_beat(CMD_READ, 1023, 0));
		script.push_back(plain_beat(CMD_NOP, 3, 5));
		// clear wipes bins and the total but keeps the registers
		script.push_back(plain_beat(CMD_CLEAR, 0, 0));
		script.push_back(plain_beat(CMD_READ, 3, 5));
		script.push_back(event_beat(1000, 1000, 1000, 1000, 0, 2000, 3, 5));
		script.push_back(plain_beat(CMD_READ, 3, 5));
		script.push_back(plain_beat(CMD_NOP, 0, 0));
		foreach (script[i])
			send_beat(script[i]);

		// Random phases, each under its own settings, each opening without idling.
		foreach (plan[p]) begin
			drain();
			write_reg(REG_GATE_LOW, APB_DATA_W'(plan[p].gate_low));
			write_reg(REG_GATE_HIGH, APB_DATA_W'(plan[p].gate_high));
			write_reg(REG_WINDOW, APB_DATA_W'(plan[p].match_window));
			write_reg(REG_OFFSET, APB_DATA_W'(plan[p].delay_offset));
			quiet = 1'b1;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (n == CALM_BEATS)
					quiet = 1'b0;
				send_beat(random_beat());
			end
		end
		drain();

		if (hist_sb.errors == 0)
			$display("coincidence_walk_histogram_tb passed");
		else
			$display("coincidence_walk_histogram_tb failed");
		$finish;
	end

endmodule

FILE: files.f
src/cwh_pkg.sv
src/cwh_lane.sv
src/cwh_merge.sv
src/cwh_store.sv
src/coincidence_walk_histogram.sv
test/coincidence_walk_histogram_tb.sv
